@@ src/ivtm_pkg.sv @@
// Shared types and constants for the interrupt vector table manager.
// No dependencies; imported by every module of the block.
`default_nettype none

package ivtm_pkg;

  // stream payload widths
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned IN_USER_W  = 2;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned RES_W      = 18;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // scan geometry
  localparam int unsigned VECTORS_PER_LEVEL = 16;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned PTR_W = 9;
  localparam logic [7:0]  PAGE_FAULT_VECTOR = 8'd14;

  // register reset values
  localparam logic [7:0] SYSCALL_RST   = 8'd128;
  localparam logic [7:0] DPC_RST       = 8'd32;
  localparam logic [7:0] TIMER_RST     = 8'd224;
  localparam logic [7:0] TLB_FLUSH_RST = 8'd225;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SYSCALL   = 2'd0,
    CFG_DPC       = 2'd1,
    CFG_TIMER     = 2'd2,
    CFG_TLB_FLUSH = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    KIND_ALLOC    = 2'd0,
    KIND_REGISTER = 2'd1,
    KIND_DISPATCH = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
  localparam logic [1:0] STATUS_IPL       = 2'd2;
  localparam logic [1:0] STATUS_UNHANDLED = 2'd3;

  // dispatch route codes
  localparam logic [2:0] ROUTE_PAGE_FAULT = 3'd0;
  localparam logic [2:0] ROUTE_DPC        = 3'd1;
  localparam logic [2:0] ROUTE_SYSCALL    = 3'd2;
  localparam logic [2:0] ROUTE_TIMER      = 3'd3;
  localparam logic [2:0] ROUTE_TLB_FLUSH  = 3'd4;
  localparam logic [2:0] ROUTE_HANDLERS   = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_READ   = 2'd1,
    ST_CHECK  = 2'd2,
    ST_FINISH = 2'd3
  } state_e;

  // one table entry beside its occupied bit
  typedef struct packed {
    logic       share;
    logic [3:0] prio;
  } ent_t;

  // one result item, status in the lowest bits
  typedef struct packed {
    logic       send_eoi;
    logic [2:0] route;
    logic [3:0] new_ipl;
    logic [7:0] vector_out;
    logic [1:0] status;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic commit;
    logic out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic hit;
    logic last;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

@@ src/ivtm_ctrl.sv @@
// Controller state machine of the interrupt vector table manager.
// Depends on ivtm_pkg; drives ivtm_dpath through cmd_t and reads sts_t.
`default_nettype none

module ivtm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire ivtm_pkg::sts_t sts_i,
  output ivtm_pkg::cmd_t     cmd_o
);
  import ivtm_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.is_alloc && !sts_i.hit && !sts_i.last) begin
          cmd_o.step = 1'b1;
        end else begin
          cmd_o.commit = 1'b1;
          state_d      = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // a new item is only taken between items
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> state_q == ST_READ)
    else $error("load did not start a table read");

  // every commit is followed by a result handoff attempt
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> state_q == ST_FINISH)
    else $error("commit did not move to finish");

  // a stepping scan never runs while idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.step |-> $past(state_q) == ST_READ || $past(state_q) == ST_CHECK)
    else $error("scan step outside of a table access");

endmodule

`default_nettype wire

@@ src/ivtm_dpath.sv @@
// Datapath of the interrupt vector table manager: config registers, item
// registers, vector table (occupied flops plus entry memory), result logic.
// Depends on ivtm_pkg; commanded by ivtm_ctrl.
`default_nettype none

module ivtm_dpath #(
  parameter int unsigned NUM_VECTORS         = 256,
  parameter int unsigned FIRST_DEVICE_VECTOR = 32
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [ivtm_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [ivtm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  wire logic [ivtm_pkg::IN_DATA_W-1:0]      in_data_i,
  input  wire logic [ivtm_pkg::IN_USER_W-1:0]      in_user_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [ivtm_pkg::OUT_DATA_W-1:0]          out_data_o,
  input  wire ivtm_pkg::cmd_t                      cmd_i,
  output ivtm_pkg::sts_t                           sts_o
);
  import ivtm_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_VECTORS);
  localparam logic [PTR_W-1:0] NUM_PTR       = PTR_W'(NUM_VECTORS);
  localparam logic [PTR_W-1:0] FIRST_DEV_PTR = PTR_W'(FIRST_DEVICE_VECTOR);

  // configuration registers
  logic [7:0] syscall_q, dpc_q, timer_q, tlb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      syscall_q <= SYSCALL_RST;
      dpc_q     <= DPC_RST;
      timer_q   <= TIMER_RST;
      tlb_q     <= TLB_FLUSH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SYSCALL:   syscall_q <= cfg_data_i;
        CFG_DPC:       dpc_q     <= cfg_data_i;
        CFG_TIMER:     timer_q   <= cfg_data_i;
        CFG_TLB_FLUSH: tlb_q     <= cfg_data_i;
        default:       syscall_q <= syscall_q;
      endcase
    end
  end

  // item registers, captured on the input transfer
  kind_e      kind_q;
  logic [7:0] vec_q;
  logic [3:0] prio_q;
  logic       share_q;
  logic [3:0] cur_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q  <= kind_e'(in_user_i);
      vec_q   <= in_data_i[7:0];
      prio_q  <= in_data_i[11:8];
      share_q <= in_data_i[12];
      cur_q   <= in_data_i[16:13];
    end
  end

  // scan pointer and step count
  logic [PTR_W-1:0] ptr_q, ptr_d, start, prio_base, rd_addr;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  assign prio_base = {1'b0, in_data_i[11:8], 4'b0000};
  assign start     = (prio_base < FIRST_DEV_PTR) ? FIRST_DEV_PTR : prio_base;

  always_comb begin
    ptr_d = ptr_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      ptr_d = (kind_e'(in_user_i) == KIND_ALLOC) ? start : {1'b0, in_data_i[7:0]};
      cnt_d = '0;
    end else if (cmd_i.step) begin
      ptr_d = ptr_q + PTR_W'(1);
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      cnt_q <= '0;
    end else begin
      ptr_q <= ptr_d;
      cnt_q <= cnt_d;
    end
  end

  // read address runs one step ahead while scanning
  assign rd_addr = cmd_i.step ? ptr_q + PTR_W'(1) : ptr_q;

  // vector table: occupied flops cleared at reset, entry memory behind them
  logic [NUM_VECTORS-1:0] occ_q;
  ent_t                   tbl_mem_q [NUM_VECTORS];
  ent_t                   ent_rd_q, wr_ent;
  logic                   occ_rd_q;
  logic                   tbl_we;
  logic [IDX_W-1:0]       wr_idx;

  assign wr_idx = ptr_q[IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    ent_rd_q <= tbl_mem_q[rd_addr[IDX_W-1:0]];
    if (tbl_we) begin
      tbl_mem_q[wr_idx] <= wr_ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      occ_rd_q <= 1'b0;
    end else begin
      occ_rd_q <= occ_q[rd_addr[IDX_W-1:0]];
      if (tbl_we) begin
        occ_q[wr_idx] <= 1'b1;
      end
    end
  end

  // entry evaluation
  logic in_range, occ_v, hit, last;

  assign in_range = ptr_q < NUM_PTR;
  assign occ_v    = occ_rd_q & in_range;
  assign hit      = in_range && (!occ_v || (ent_rd_q.share && share_q));
  assign last     = cnt_q == CNT_W'(VECTORS_PER_LEVEL - 1);

  // handler merge: first handler sets sharing, later ones raise the maximum
  always_comb begin
    if (occ_v) begin
      wr_ent.share = ent_rd_q.share;
      wr_ent.prio  = (prio_q > ent_rd_q.prio) ? prio_q : ent_rd_q.prio;
    end else begin
      wr_ent.share = share_q;
      wr_ent.prio  = prio_q;
    end
  end

  assign tbl_we = cmd_i.commit &&
                  (((kind_q == KIND_ALLOC) && hit) ||
                   ((kind_q == KIND_REGISTER) && in_range));

  // result of the current item
  res_t       res_d, res_q;
  logic [3:0] lvl0;
  logic       viol;

  assign lvl0 = (vec_q == syscall_q) ? 4'd0 : vec_q[7:4];
  assign viol = cur_q > lvl0;

  always_comb begin
    res_d            = '0;
    res_d.status     = STATUS_OK;
    res_d.vector_out = vec_q;
    case (kind_q)
      KIND_ALLOC: begin
        if (hit) begin
          res_d.vector_out = ptr_q[7:0];
        end else begin
          res_d.status     = STATUS_NO_FREE;
          res_d.vector_out = 8'd0;
        end
      end
      KIND_REGISTER: begin
        if (!in_range) begin
          res_d.status = STATUS_NO_FREE;
        end
      end
      KIND_DISPATCH: begin
        res_d.new_ipl = lvl0;
        if (vec_q == PAGE_FAULT_VECTOR) begin
          res_d.route = ROUTE_PAGE_FAULT;
        end else if (vec_q == dpc_q) begin
          res_d.route    = ROUTE_DPC;
          res_d.send_eoi = 1'b1;
        end else if (vec_q == syscall_q) begin
          res_d.route = ROUTE_SYSCALL;
        end else if (vec_q == timer_q) begin
          res_d.route    = ROUTE_TIMER;
          res_d.send_eoi = 1'b1;
        end else if (vec_q == tlb_q) begin
          res_d.route    = ROUTE_TLB_FLUSH;
          res_d.send_eoi = 1'b1;
        end else begin
          res_d.route = ROUTE_HANDLERS;
          if (!occ_v) begin
            res_d.status = STATUS_UNHANDLED;
          end else begin
            if (ent_rd_q.prio > lvl0) begin
              res_d.new_ipl = ent_rd_q.prio;
            end
            res_d.send_eoi = {1'b0, vec_q} >= FIRST_DEV_PTR;
          end
        end
        // level violation overrides status and suppresses eoi
        if (viol) begin
          res_d.status   = STATUS_IPL;
          res_d.send_eoi = 1'b0;
        end
      end
      default: begin
        res_d.vector_out = vec_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_q <= res_d;
    end
  end

  // output register
  logic             out_valid_q;
  logic [RES_W-1:0] out_data_q;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q <= res_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {(OUT_DATA_W - RES_W)'(0), out_data_q};

  // status to controller
  assign sts_o.is_alloc = kind_q == KIND_ALLOC;
  assign sts_o.hit      = hit;
  assign sts_o.last     = last;
  assign sts_o.out_free = out_free;

  // table writes stay inside the table
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |-> in_range)
    else $error("table write outside the table");

  // a scan never runs past its sixteen vectors
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> (kind_q == KIND_ALLOC) && !hit && !last)
    else $error("scan stepped past a hit or its window");

  // a written vector is occupied afterwards
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_we |=> occ_q[$past(wr_idx)])
    else $error("written vector not marked occupied");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> out_free)
    else $error("result register overwritten while pending");

endmodule

`default_nettype wire

@@ src/interrupt_vector_table_manager.sv @@
// Top level of the interrupt vector table manager.
// Depends on ivtm_pkg, ivtm_ctrl and ivtm_dpath.
//
//  channel   direction  handshake                     payload
//  s_axis    in         s_axis_tvalid/s_axis_tready   tdata, tuser (kind)
//  m_axis    out        m_axis_tvalid/m_axis_tready   tdata (result)
//  cfg       in         cfg_we_i (no wait)            cfg_idx_i, cfg_data_i
//
// An item passes from its input transfer to the result register through a
// table read, then an examination of one table entry per step (one entry
// for register and dispatch, up to 16 for an allocate scan, limited by the
// single read port of the entry memory), then a hand-off.
// The next input transfer is taken as soon as the result moves to the
// output register, even if that result is still waiting to be taken.
// Reset clears the occupied bits at once; no clearing pass is needed.
`default_nettype none

module interrupt_vector_table_manager #(
  parameter int unsigned NUM_VECTORS         = 256,
  parameter int unsigned FIRST_DEVICE_VECTOR = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration write port
  input  wire logic                              cfg_we_i,
  input  wire logic [ivtm_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ivtm_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input items
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // vector[7:0], prio[11:8], shareable[12], current_ipl[16:13], zero fill
  input  wire logic [ivtm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // kind[1:0]
  input  wire logic [ivtm_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // result items
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // status[1:0], vector_out[9:2], new_ipl[13:10], route[16:14],
  // send_eoi[17], zero fill
  output logic [ivtm_pkg::OUT_DATA_W-1:0]        m_axis_tdata
);
  import ivtm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  ivtm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // table and result datapath
  ivtm_dpath #(
    .NUM_VECTORS         (NUM_VECTORS),
    .FIRST_DEVICE_VECTOR (FIRST_DEVICE_VECTOR)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

`default_nettype wire
